@@ sv/lhc_pkg.sv @@
// Shared types, constants and codes for the LRU handle cache.
package lhc_pkg;

    localparam int NUM_WAYS  = 4;
    localparam int NUM_KEYS  = 8;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int KEY_W     = 8;
    localparam int STAMP_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int OUT_WAY_W = 4;

    localparam logic [STAMP_W-1:0] STAMP_MAX = {STAMP_W{1'b1}};

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT    = 3'd0,
        ST_FILL   = 3'd1,
        ST_EVICT  = 3'd2,
        ST_REJECT = 3'd3,
        ST_FLUSH  = 3'd4
    } status_t;

    typedef enum logic {
        KIND_LOOKUP = 1'b0,
        KIND_FLUSH  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } state_t;

    // Search request that walks down the row of ways, one way per cycle.
    typedef struct packed {
        logic               act;
        logic [KEY_W-1:0]   key;
        logic               hit;
        logic [WAY_W-1:0]   hit_way;
        logic               empty;
        logic [WAY_W-1:0]   empty_way;
        logic               min_found;
        logic [STAMP_W-1:0] min_stamp;
        logic [WAY_W-1:0]   min_way;
        logic [KEY_W-1:0]   min_key;
    } probe_t;

    // Update broadcast from the controller to every way.
    typedef struct packed {
        logic               flush;
        logic               we;
        logic [WAY_W-1:0]   way;
        logic [KEY_W-1:0]   key;
        logic [STAMP_W-1:0] stamp;
    } upd_t;

endpackage

@@ sv/lhc_cell.sv @@
// One cache way: holds valid, key and stamp, and passes the search request on.
module lhc_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [lhc_pkg::WAY_W-1:0] idx,
    input  lhc_pkg::probe_t         probe_in,
    input  lhc_pkg::upd_t           upd,
    output lhc_pkg::probe_t         probe_out
);
    import lhc_pkg::*;

    logic               valid_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [STAMP_W-1:0] stamp_reg;
    probe_t             probe_reg;
    probe_t             probe_next;

    always_comb
    begin
        probe_next = probe_in;
        if (valid_reg && key_reg == probe_in.key && !probe_in.hit)
        begin
            probe_next.hit     = 1'b1;
            probe_next.hit_way = idx;
        end
        if (!valid_reg && !probe_in.empty)
        begin
            probe_next.empty     = 1'b1;
            probe_next.empty_way = idx;
        end
        // Strict compare keeps the lowest way on equal stamps.
        if (!probe_in.min_found || stamp_reg < probe_in.min_stamp)
        begin
            probe_next.min_found = 1'b1;
            probe_next.min_stamp = stamp_reg;
            probe_next.min_way   = idx;
            probe_next.min_key   = key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stamp_reg <= '0;
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
            if (upd.flush)
            begin
                valid_reg <= 1'b0;
                stamp_reg <= '0;
            end
            else if (upd.we && upd.way == idx)
            begin
                valid_reg <= 1'b1;
                stamp_reg <= upd.stamp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!upd.flush && upd.we && upd.way == idx)
        begin
            key_reg <= upd.key;
        end
    end

    assign probe_out = probe_reg;

endmodule

@@ sv/lru_handle_cache_top.sv @@
// Top level of the LRU handle cache: controller, row of way cells and output register.
//
// This block is a small fully associative cache of lhc_pkg::NUM_WAYS ways keyed by an
// algorithm number, with least-recently-used replacement by use timestamps. Each request
// carries a kind on s_tuser (lookup or flush) and a key on s_tdata, and yields exactly one
// result on the master side. A lookup request walks down a row of way cells, one cell per
// clock, collecting the hit way, the first empty way and the way with the smallest stamp
// (lowest way on ties); the update is then broadcast to all cells at once. A lookup is
// accepted, walks the row, and then writes back and loads the output register once that
// register is free; rejected keys and flushes skip the walk. One request is in flight at
// a time; the next request is taken as soon as the result sits in the output register,
// even if the consumer has not yet taken it. The use clock saturates at its maximum rather
// than wrapping. Stored keys have no reset and are only used in a result for ways that
// are valid.
module lru_handle_cache_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] algo_key
    input  logic [0:0]  s_tuser,   // [0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [3:0] way, [11:4] evicted_key, [15:12] zero
    output logic [2:0]  m_tuser    // [2:0] status
);
    import lhc_pkg::*;

    state_t              state_reg, state_next;
    logic [STAMP_W-1:0]  clock_reg;
    status_t             res_status_reg, res_status_next;
    logic [WAY_W-1:0]    res_way_reg, res_way_next;
    logic [KEY_W-1:0]    res_evict_reg, res_evict_next;
    logic [KEY_W-1:0]    res_key_reg, res_key_next;
    logic [STAMP_W-1:0]  res_stamp_reg, res_stamp_next;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [WAY_W-1:0]    out_way_reg;
    logic [KEY_W-1:0]    out_evict_reg;

    probe_t              probe [NUM_WAYS+1];
    upd_t                upd;
    logic                accept;
    logic                out_free;
    logic                load_out;
    logic                key_ok;
    logic [STAMP_W-1:0]  stamp_inc;
    probe_t              tail;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign key_ok   = {1'b0, s_tdata} < (KEY_W+1)'(NUM_KEYS);
    assign stamp_inc = (clock_reg == STAMP_MAX) ? STAMP_MAX : clock_reg + 1'b1;
    assign tail     = probe[NUM_WAYS];

    // Search request entering the first cell.
    always_comb
    begin
        probe[0]     = '0;
        probe[0].act = accept && s_tuser[0] == KIND_LOOKUP && key_ok;
        probe[0].key = s_tdata;
    end

    for (genvar g = 0; g < NUM_WAYS; g++)
    begin : g_way
        lhc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .idx       (WAY_W'(g)),
            .probe_in  (probe[g]),
            .upd       (upd),
            .probe_out (probe[g+1])
        );
    end

    // Controller: next state and result capture.
    always_comb
    begin
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_way_next    = res_way_reg;
        res_evict_next  = res_evict_reg;
        res_key_next    = res_key_reg;
        res_stamp_next  = res_stamp_reg;
        s_tready        = 1'b0;
        load_out        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    res_way_next   = '0;
                    res_evict_next = '0;
                    res_key_next   = s_tdata;
                    if (s_tuser[0] == KIND_FLUSH)
                    begin
                        res_status_next = ST_FLUSH;
                        state_next      = S_RESP;
                    end
                    else if (!key_ok)
                    begin
                        res_status_next = ST_REJECT;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (tail.act)
                begin
                    res_stamp_next = stamp_inc;
                    if (tail.hit)
                    begin
                        res_status_next = ST_HIT;
                        res_way_next    = tail.hit_way;
                    end
                    else if (tail.empty)
                    begin
                        res_status_next = ST_FILL;
                        res_way_next    = tail.empty_way;
                    end
                    else
                    begin
                        res_status_next = ST_EVICT;
                        res_way_next    = tail.min_way;
                        res_evict_next  = tail.min_key;
                    end
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Update broadcast, applied when the result moves into the output register.
    always_comb
    begin
        upd       = '0;
        upd.flush = load_out && res_status_reg == ST_FLUSH;
        upd.we    = load_out && (res_status_reg == ST_HIT || res_status_reg == ST_FILL
                                 || res_status_reg == ST_EVICT);
        upd.way   = res_way_reg;
        upd.key   = res_key_reg;
        upd.stamp = res_stamp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            clock_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd.flush)
            begin
                clock_reg <= '0;
            end
            else if (upd.we)
            begin
                clock_reg <= res_stamp_reg;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_way_reg    <= res_way_next;
        res_evict_reg  <= res_evict_next;
        res_key_reg    <= res_key_next;
        res_stamp_reg  <= res_stamp_next;
        if (load_out)
        begin
            out_status_reg <= res_status_reg;
            out_way_reg    <= res_way_reg;
            out_evict_reg  <= res_evict_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {4'b0000, out_evict_reg, OUT_WAY_W'(out_way_reg)};

    // A search request only reaches the end of the row while the controller waits for it.
    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.act |-> state_reg == S_SCAN)
        else $error("search request finished outside the scan state");

    // Only one search request is ever in flight in the row; checked on the first and last cells.
    a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $countones({probe[NUM_WAYS].act, probe[1].act}) <= 1)
        else $error("more than one search request in the row");

    // A new request is never taken while the previous one is still being worked on.
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_RESP) |-> !s_tready)
        else $error("request accepted while busy");

    // An accepted flush request goes straight to the response state.
    a_flush_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser[0] == KIND_FLUSH) |=> state_reg == S_RESP)
        else $error("flush did not go straight to the response state");

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the LRU handle cache: directed and random requests, scoreboard.
module tb;
    import lhc_pkg::*;

    // One result as the block reports it on the master side.
    typedef struct {
        status_t               status;
        logic [OUT_WAY_W-1:0]  way;
        logic [KEY_W-1:0]      evicted_key;
    } cache_result_t;

    // Scoreboard: holds its own copy of the cache contents, predicts the result of every
    // accepted request, and compares delivered results against the oldest prediction.
    class lru_result_board;
        logic                way_valid [NUM_WAYS];
        logic [KEY_W-1:0]    way_key   [NUM_WAYS];
        logic [STAMP_W-1:0]  way_stamp [NUM_WAYS];
        logic [STAMP_W-1:0]  use_clock;
        cache_result_t       awaited_results [$];
        int unsigned         errors;
        int unsigned         status_seen [5];

        function new();
            for (int i = 0; i < NUM_WAYS; i++)
            begin
                way_valid[i] = 1'b0;
                way_key[i]   = '0;
                way_stamp[i] = '0;
            end
            use_clock = '0;
            errors    = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        // The use clock sticks at its maximum instead of wrapping.
        function logic [STAMP_W-1:0] advance_use_clock();
            if (use_clock != STAMP_MAX)
                use_clock = use_clock + 1'b1;
            return use_clock;
        endfunction

        // Works out the result of one accepted request and updates the cache copy.
        function void note_request(kind_t kind, logic [KEY_W-1:0] key);
            cache_result_t       res;
            int                  hit_way;
            int                  victim;
            logic [STAMP_W-1:0]  least;

            res.status      = ST_REJECT;
            res.way         = '0;
            res.evicted_key = '0;
            hit_way         = -1;
            victim          = -1;
            if (kind == KIND_FLUSH)
            begin
                for (int i = 0; i < NUM_WAYS; i++)
                begin
                    way_valid[i] = 1'b0;
                    way_stamp[i] = '0;
                end
                use_clock  = '0;
                res.status = ST_FLUSH;
            end
            else if (key < NUM_KEYS)
            begin
                for (int i = 0; i < NUM_WAYS; i++)
                begin
                    if (hit_way < 0 && way_valid[i] && way_key[i] == key)
                        hit_way = i;
                end
                if (hit_way >= 0)
                begin
                    way_stamp[hit_way] = advance_use_clock();
                    res.status         = ST_HIT;
                    res.way            = OUT_WAY_W'(hit_way);
                end
                else
                begin
                    for (int i = 0; i < NUM_WAYS; i++)
                    begin
                        if (victim < 0 && !way_valid[i])
                            victim = i;
                    end
                    if (victim >= 0)
                        res.status = ST_FILL;
                    else
                    begin
                        // Strict less-than keeps the lowest way on equal stamps.
                        victim = 0;
                        least  = way_stamp[0];
                        for (int i = 1; i < NUM_WAYS; i++)
                        begin
                            if (way_stamp[i] < least)
                            begin
                                least  = way_stamp[i];
                                victim = i;
                            end
                        end
                        res.status      = ST_EVICT;
                        res.evicted_key = way_key[victim];
                    end
                    way_valid[victim] = 1'b1;
                    way_key[victim]   = key;
                    way_stamp[victim] = advance_use_clock();
                    res.way           = OUT_WAY_W'(victim);
                end
            end
            awaited_results.push_back(res);
        endfunction

        function void check_result(logic [STATUS_W-1:0] status, logic [OUT_WAY_W-1:0] way,
                                   logic [KEY_W-1:0] evicted_key);
            cache_result_t exp;

            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result status %0d way %0d evicted_key %0d",
                         $time, status, way, evicted_key);
                errors++;
                return;
            end
            exp = awaited_results.pop_front();
            if (status !== exp.status)
            begin
                $display("%0t: status expected %0d, actual %0d", $time, exp.status, status);
                errors++;
            end
            if (way !== exp.way)
            begin
                $display("%0t: way expected %0d, actual %0d", $time, exp.way, way);
                errors++;
            end
            if (evicted_key !== exp.evicted_key)
            begin
                $display("%0t: evicted_key expected %0d, actual %0d",
                         $time, exp.evicted_key, evicted_key);
                errors++;
            end
            if (exp.status <= ST_FLUSH)
                status_seen[exp.status]++;
        endfunction

        function int outstanding();
            return awaited_results.size();
        endfunction
    endclass

    localparam int RANDOM_REQUESTS = 1100;
    // Cycles without any handshake on either side before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off below plus a few random gaps.
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLDOFF_CYCLES  = 80;
    localparam int SETTLE_CYCLES   = 3 * (NUM_WAYS + 2);

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [2:0]  m_tuser;

    lru_result_board board = new();

    // Random idling on both sides is switched off for one long stretch of the run.
    bit          gaps_on     = 1'b1;
    // When set, the receiver drops tready for this many cycles, counted down by itself.
    int          hold_cycles = 0;
    int unsigned quiet_cycles = 0;

    lru_handle_cache_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // Offers one request, starting at a falling edge, and returns at the falling edge after
    // it has been accepted. A request that follows directly keeps tvalid high without a dip.
    task automatic send_request(kind_t kind, logic [KEY_W-1:0] key);
        while (gaps_on && $urandom_range(0, 99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= key;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(kind, key);
        @(negedge clk);
    endtask

    // Called at a falling edge; returns at a falling edge once every result has come.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Receiver: tready changes at the falling edge, results are taken at the rising edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
                m_tready <= !(gaps_on && $urandom_range(0, 99) < 11);
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_result(m_tuser, m_tdata[3:0], m_tdata[11:4]);
        end
    end

    // Watchdog: a run that stops moving for too long is a failure.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d results still awaited",
                         $time, quiet_cycles, board.outstanding());
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        int roll;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part. Keys at both ends of the legal range fill the first ways, keys just
        // past the range and at the top of the field are rejected, a repeated key hits, and a
        // full cache makes the least recently used way give up its key.
        send_request(KIND_LOOKUP, 8'd0);
        send_request(KIND_LOOKUP, KEY_W'(NUM_KEYS - 1));
        send_request(KIND_LOOKUP, KEY_W'(NUM_KEYS));
        send_request(KIND_LOOKUP, 8'hFF);
        send_request(KIND_LOOKUP, 8'd0);
        send_request(KIND_LOOKUP, 8'd1);
        send_request(KIND_LOOKUP, 8'd2);
        send_request(KIND_LOOKUP, 8'd3);
        send_request(KIND_LOOKUP, KEY_W'(NUM_KEYS - 1));
        send_request(KIND_LOOKUP, 8'd0);
        send_request(KIND_LOOKUP, 8'd4);
        send_request(KIND_LOOKUP, 8'hAA);
        send_request(KIND_LOOKUP, 8'h55);
        // A flush ignores its key field; afterwards the old keys must miss again.
        send_request(KIND_FLUSH, 8'hFF);
        send_request(KIND_LOOKUP, 8'd0);
        send_request(KIND_LOOKUP, 8'd4);
        send_request(KIND_FLUSH, 8'd0);
        send_request(KIND_FLUSH, 8'h5A);
        send_request(KIND_LOOKUP, KEY_W'(NUM_KEYS - 1));
        send_request(KIND_LOOKUP, KEY_W'(NUM_KEYS - 1));
        send_request(KIND_LOOKUP, 8'h80);

        // Random part. Most requests are lookups of legal keys, 38 in every 100 requests from a small hot
        // set so that hits and evictions both happen often; the rest are stray keys anywhere
        // in the field and the occasional flush.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if (n == 300)
                gaps_on = 1'b0;
            if (n == 500)
                gaps_on = 1'b1;
            // The receiver stalls while requests keep coming, so the block backs up.
            if (n == 650)
                hold_cycles = HOLDOFF_CYCLES;
            // The sender waits here until the block has answered everything.
            if (n == 850)
                wait_for_results();
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_request(KIND_FLUSH, KEY_W'($urandom_range(0, 255)));
            else if (roll < 12)
                send_request(KIND_LOOKUP, KEY_W'($urandom_range(0, 255)));
            else if (roll < 50)
                send_request(KIND_LOOKUP, KEY_W'($urandom_range(0, NUM_KEYS / 2)));
            else
                send_request(KIND_LOOKUP, KEY_W'($urandom_range(0, NUM_KEYS - 1)));
        end

        wait_for_results();
        // Any result that shows up now is extra and counts against the run.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.outstanding() != 0)
            board.errors++;

        $display("Covered %0d hits, %0d fills of empty ways, %0d evictions,",
                 board.status_seen[ST_HIT], board.status_seen[ST_FILL],
                 board.status_seen[ST_EVICT]);
        $display("%0d rejected keys and %0d flushes, with stalls and back-pressure on both sides.",
                 board.status_seen[ST_REJECT], board.status_seen[ST_FLUSH]);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
